>>> hw/rtl/skrb_pkg.sv
// shared types, constants and the microcode table of the range brake filter
// no dependencies; used by every module of the block
package skrb_pkg;

	// field and storage widths fixed by the interface
	localparam int DIST_W = 16;
	localparam int VAR_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;

	// default fixed-point formats
	localparam int EST_FRAC_BITS_DEF = 8;
	localparam int COV_FRAC_BITS_DEF = 16;

	// register reset values
	localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 24'd98304;
	localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 24'd65536;
	localparam logic [DIST_W-1:0] MAX_RANGE_RST = 16'd8000;
	localparam logic [DIST_W-1:0] BRAKE_MM_RST = 16'd3000;
	localparam logic [VAR_W-1:0] VARIANCE_RST = 24'd9830;
	localparam logic [DIST_W-1:0] ESTIMATE_RST_MM = 16'd10000;

	// divide by ten for 24-bit values: multiply by ceil(2^27 / 10), keep the top
	localparam logic [VAR_W-1:0] DIV10_MUL = 24'hCCCCCD;
	localparam int DIV10_SHIFT = 27;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MM = 2'd3;

	// microcode store
	localparam int UC_DEPTH = 8;
	localparam int PC_W = $clog2(UC_DEPTH);

	localparam logic [PC_W-1:0] ST_IDLE = 3'd0;
	localparam logic [PC_W-1:0] ST_SETUP = 3'd1;
	localparam logic [PC_W-1:0] ST_DIV = 3'd2;
	localparam logic [PC_W-1:0] ST_MAG = 3'd3;
	localparam logic [PC_W-1:0] ST_MUL_EST = 3'd4;
	localparam logic [PC_W-1:0] ST_MUL_VAR = 3'd5;
	localparam logic [PC_W-1:0] ST_COMMIT = 3'd6;
	localparam logic [PC_W-1:0] ST_RETURN = 3'd7;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SETUP,
		OP_DIV,
		OP_MAG,
		OP_MUL_EST,
		OP_MUL_VAR,
		OP_COMMIT
	} op_t;

	// jump conditions: a true condition loads the target, else the next step
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_WAIT_IN,
		C_LOOP,
		C_WAIT_OUT
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
		logic cnt_load;
	} uword_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [VAR_W-1:0] process_noise;
		logic [VAR_W-1:0] measurement_noise;
		logic [DIST_W-1:0] max_range_mm;
		logic [DIST_W-1:0] brake_mm;
	} cfg_t;

	// sequencer to datapath
	typedef struct packed {
		op_t op;
		logic fire;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_range;
		logic out_free;
	} status_t;

	// the update program
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, cnt_load: 1'b0};
		case (pc)
			ST_IDLE: w = '{op: OP_LOAD, cond: C_WAIT_IN, target: ST_IDLE, cnt_load: 1'b0};
			ST_SETUP: w = '{op: OP_SETUP, cond: C_NEXT, target: ST_IDLE, cnt_load: 1'b1};
			ST_DIV: w = '{op: OP_DIV, cond: C_LOOP, target: ST_DIV, cnt_load: 1'b0};
			ST_MAG: w = '{op: OP_MAG, cond: C_NEXT, target: ST_IDLE, cnt_load: 1'b0};
			ST_MUL_EST: w = '{op: OP_MUL_EST, cond: C_NEXT, target: ST_IDLE, cnt_load: 1'b0};
			ST_MUL_VAR: w = '{op: OP_MUL_VAR, cond: C_NEXT, target: ST_IDLE, cnt_load: 1'b0};
			ST_COMMIT: w = '{op: OP_COMMIT, cond: C_WAIT_OUT, target: ST_COMMIT, cnt_load: 1'b0};
			ST_RETURN: w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, cnt_load: 1'b0};
			default: w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, cnt_load: 1'b0};
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/skrb_sequencer.sv
// microcode sequencer: step counter, loop counter and jump logic
// depends on skrb_pkg for the control word format and the program
module skrb_sequencer #(
	parameter int COV_FRAC_BITS = skrb_pkg::COV_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  skrb_pkg::status_t   status,
	output skrb_pkg::ctrl_t     ctrl
);
	import skrb_pkg::*;

	localparam int CNT_W = $clog2(COV_FRAC_BITS + 1);

	logic [PC_W-1:0] pc_q;
	logic [CNT_W-1:0] cnt_q;
	uword_t word;
	logic jump;

	// current control word
	assign word = ucode_rom(pc_q);
	assign in_ready = (word.op == OP_LOAD);

	// operation enable per step
	always_comb begin
		ctrl.op = word.op;
		case (word.op)
			OP_LOAD: ctrl.fire = in_valid;
			OP_COMMIT: ctrl.fire = status.out_free;
			default: ctrl.fire = 1'b1;
		endcase
	end

	// jump condition
	always_comb begin
		case (word.cond)
			C_NEXT: jump = 1'b0;
			C_ALWAYS: jump = 1'b1;
			C_WAIT_IN: jump = !(in_valid && status.in_range);
			C_LOOP: jump = (cnt_q != '0);
			C_WAIT_OUT: jump = !status.out_free;
			default: jump = 1'b1;
		endcase
	end

	// step and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q <= jump ? word.target : pc_q + 1'b1;
			if (word.cnt_load) begin
				cnt_q <= CNT_W'(COV_FRAC_BITS);
			end else if (word.cond == C_LOOP && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/skrb_datapath.sv
// filter datapath: gain divider, shared multiplier, filter state and result register
// depends on skrb_pkg; skrb_sequencer drives one operation per cycle unless stalled
module skrb_datapath #(
	parameter int EST_FRAC_BITS = skrb_pkg::EST_FRAC_BITS_DEF,
	parameter int COV_FRAC_BITS = skrb_pkg::COV_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skrb_pkg::ctrl_t                   ctrl,
	input  skrb_pkg::cfg_t                    cfg,
	input  logic                              var_load,
	input  logic [skrb_pkg::VAR_W-1:0]        var_load_data,
	input  logic [skrb_pkg::DIST_W-1:0]       distance_mm,
	output skrb_pkg::status_t                 status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [skrb_pkg::DIST_W-1:0]       filtered_mm,
	output logic                              brake
);
	import skrb_pkg::*;

	localparam int EST_W = DIST_W + EST_FRAC_BITS;
	localparam int PRIOR_W = VAR_W + 1;
	localparam int DEN_W = VAR_W + 2;
	localparam int REM_W = VAR_W + 3;
	localparam int GAIN_W = COV_FRAC_BITS + 1;
	localparam int MB_W = (EST_W > PRIOR_W) ? EST_W : PRIOR_W;
	localparam int PROD_W = GAIN_W + MB_W;
	localparam int D10_W = 2 * VAR_W + 4;
	localparam logic [EST_W-1:0] EST_RST = EST_W'(ESTIMATE_RST_MM) << EST_FRAC_BITS;

	// filter state
	logic [EST_W-1:0] est_q, older_q;
	logic [VAR_W-1:0] var_q;
	// working registers
	logic [EST_W-1:0] meas_q, mag_q, step_q;
	logic [PRIOR_W-1:0] prior_q, shrink_q;
	logic [DEN_W-1:0] denom_q;
	logic den_zero_q;
	logic [REM_W-1:0] rem_q;
	logic [GAIN_W-1:0] gain_q;
	logic sign_q;
	// result register
	logic out_valid_q, brake_q;
	logic [DIST_W-1:0] filtered_q;

	logic do_load, do_setup, do_div, do_mag, do_mul_est, do_mul_var, do_commit;
	logic [DEN_W-1:0] denom;
	logic div_ge;
	logic [REM_W-1:0] div_diff;
	logic [MB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod, prod_sh;
	logic [EST_W-1:0] new_est, thr;
	logic [PRIOR_W-1:0] var_diff;
	logic [VAR_W-1:0] new_var;
	logic new_brake;
	logic [D10_W-1:0] div10;

	assign do_load = ctrl.fire && ctrl.op == OP_LOAD;
	assign do_setup = ctrl.fire && ctrl.op == OP_SETUP;
	assign do_div = ctrl.fire && ctrl.op == OP_DIV;
	assign do_mag = ctrl.fire && ctrl.op == OP_MAG;
	assign do_mul_est = ctrl.fire && ctrl.op == OP_MUL_EST;
	assign do_mul_var = ctrl.fire && ctrl.op == OP_MUL_VAR;
	assign do_commit = ctrl.fire && ctrl.op == OP_COMMIT;

	// status towards the sequencer
	assign status.in_range = (distance_mm <= cfg.max_range_mm);
	assign status.out_free = !out_valid_q || out_ready;

	// gain denominator
	assign denom = DEN_W'(prior_q) + DEN_W'(cfg.measurement_noise);

	// one restoring division step, a zero denominator gives a zero gain
	assign div_ge = (rem_q >= REM_W'(denom_q)) && !den_zero_q;
	assign div_diff = div_ge ? rem_q - REM_W'(denom_q) : rem_q;

	// shared multiplier, gain times magnitude or gain times prior
	assign mul_b = (ctrl.op == OP_MUL_VAR) ? MB_W'(prior_q) : MB_W'(mag_q);
	assign prod = PROD_W'(gain_q) * PROD_W'(mul_b);
	assign prod_sh = prod >> COV_FRAC_BITS;

	// new estimate, variance and brake decision
	assign new_est = sign_q ? est_q + step_q : est_q - step_q;
	assign var_diff = (shrink_q >= prior_q) ? '0 : prior_q - shrink_q;
	assign new_var = var_diff[PRIOR_W-1] ? {VAR_W{1'b1}} : var_diff[VAR_W-1:0];
	assign thr = EST_W'(cfg.brake_mm) << EST_FRAC_BITS;
	assign new_brake = (new_est < thr) && (est_q < thr) && (older_q < thr);

	// variance reload on a process noise write
	assign div10 = D10_W'(var_load_data) * D10_W'(DIV10_MUL);

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= EST_RST;
			older_q <= EST_RST;
			var_q <= VARIANCE_RST;
		end else begin
			if (do_commit) begin
				older_q <= est_q;
				est_q <= new_est;
			end
			if (var_load) begin
				var_q <= VAR_W'(div10 >> DIV10_SHIFT);
			end else if (do_commit) begin
				var_q <= new_var;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (do_load) begin
			meas_q <= EST_W'(distance_mm) << EST_FRAC_BITS;
			prior_q <= PRIOR_W'(var_q) + PRIOR_W'(cfg.process_noise);
		end
		if (do_setup) begin
			denom_q <= denom;
			den_zero_q <= (denom == '0);
			rem_q <= REM_W'(prior_q);
			gain_q <= '0;
		end
		if (do_div) begin
			rem_q <= {div_diff[REM_W-2:0], 1'b0};
			gain_q <= {gain_q[GAIN_W-2:0], div_ge};
		end
		if (do_mag) begin
			sign_q <= (meas_q >= est_q);
			mag_q <= (meas_q >= est_q) ? meas_q - est_q : est_q - meas_q;
		end
		if (do_mul_est) begin
			step_q <= EST_W'(prod_sh);
		end
		if (do_mul_var) begin
			shrink_q <= PRIOR_W'(prod_sh);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_commit) begin
			filtered_q <= new_est[EST_W-1:EST_FRAC_BITS];
			brake_q <= new_brake;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_mm = filtered_q;
	assign brake = brake_q;

endmodule

>>> hw/rtl/scalar_kalman_range_brake.sv
// Scalar Kalman range filter with brake detection. Each accepted range reading in
// millimetres either is dropped (above max_range_mm, no result) or runs a one-dimensional
// Kalman update and gives the filtered distance and a brake flag set when the last three
// estimates lie below brake_mm. A microcoded sequencer runs the update as load, setup,
// the bit-serial gain division, which resolves one quotient bit per cycle for a gain of
// COV_FRAC_BITS + 1 bits, magnitude, the two multiplies and commit; one update runs at a
// time, so a new request is taken only once the sequencer is back at its idle step. The next
// request is taken while a result waits in the output register; that update then holds
// at its commit step until the output register is free. Writing process_noise reloads
// the error variance with one tenth of the written value. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// top level: configuration registers, sequencer and datapath
// depends on skrb_pkg, skrb_sequencer and skrb_datapath
module scalar_kalman_range_brake #(
	parameter int EST_FRAC_BITS = skrb_pkg::EST_FRAC_BITS_DEF,
	parameter int COV_FRAC_BITS = skrb_pkg::COV_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [skrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [skrb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [skrb_pkg::DIST_W-1:0]       distance_mm,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [skrb_pkg::DIST_W-1:0]       filtered_mm,
	output logic                              brake
);
	import skrb_pkg::*;

	cfg_t cfg_q;
	ctrl_t ctrl;
	status_t status;
	logic var_load;

	assign var_load = cfg_we && (cfg_index == REG_PROCESS_NOISE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.process_noise <= PROCESS_NOISE_RST;
			cfg_q.measurement_noise <= MEASUREMENT_NOISE_RST;
			cfg_q.max_range_mm <= MAX_RANGE_RST;
			cfg_q.brake_mm <= BRAKE_MM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROCESS_NOISE: cfg_q.process_noise <= cfg_data[VAR_W-1:0];
				REG_MEASUREMENT_NOISE: cfg_q.measurement_noise <= cfg_data[VAR_W-1:0];
				REG_MAX_RANGE: cfg_q.max_range_mm <= cfg_data[DIST_W-1:0];
				REG_BRAKE_MM: cfg_q.brake_mm <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// control program
	skrb_sequencer #(
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.ctrl(ctrl)
	);

	// arithmetic and state
	skrb_datapath #(
		.EST_FRAC_BITS(EST_FRAC_BITS),
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.cfg(cfg_q),
		.var_load(var_load),
		.var_load_data(cfg_data[VAR_W-1:0]),
		.distance_mm(distance_mm),
		.status(status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered_mm(filtered_mm),
		.brake(brake)
	);

endmodule
